>>> rtl/rfd_pkg.sv
package rfd_pkg;

    localparam int FULL_AUTH_LEN  = 6;
    localparam int SHORT_AUTH_LEN = 2;
    localparam int HDR_BYTES      = 8;
    localparam int CMD_POS        = 8;
    localparam int MIN_FRAME      = 13;
    localparam int BASE_OVERHEAD  = 11;
    localparam int POS_MAX        = 63;

    localparam logic [7:0]  CMD_SHORT_AUTH = 8'h30;
    localparam logic [15:0] CRC_POLY_RESET = 16'h8408;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_CRC_MISMATCH = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_OVERHEAD     = 3'd4
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  control_first;
        logic [7:0]  control_second;
        logic [23:0] dest_address;
        logic [23:0] source_address;
        logic [7:0]  command;
        logic [15:0] rolling_counter;
        logic [47:0] auth_code;
        logic [3:0]  auth_len;
        logic [4:0]  payload_len;
    } result_t;

    // reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> rtl/radio_frame_deframer.sv
// A result is registered in the output register, or in the skid register when
// the output stalls. One byte per cycle while the skid is empty; the 8-bit
// unrolled CRC update and field capture sit between the state registers and
// the result register. The skid register behind the result register keeps
// input flowing for one stalled result. Reset (rst_n, asynchronous) clears the
// frame state, empties both output stages and loads the CRC polynomial with 0x8408.
module radio_frame_deframer
    import rfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status,
    output logic [7:0]  control_first,
    output logic [7:0]  control_second,
    output logic [23:0] dest_address,
    output logic [23:0] source_address,
    output logic [7:0]  command,
    output logic [15:0] rolling_counter,
    output logic [47:0] auth_code,
    output logic [3:0]  auth_len,
    output logic [4:0]  payload_len
);

    logic [15:0] poly_reg;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [63:0] header_reg, header_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] counter_reg, counter_next;
    logic [47:0] auth_reg, auth_next;

    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        accept;
    logic        is_payload;
    logic        res_valid;
    result_t     res;

    logic [5:0]  body, over, pl;
    logic [3:0]  alen;
    logic        fits;
    logic [6:0]  pos7, pay_end, cnt_end, auth_end;

    logic [5:0]  body_f, over_f;
    logic [3:0]  alen_f;
    logic [6:0]  len7;
    logic [15:0] rx_crc;
    status_t     st;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    // layout as known before this byte
    always_comb
    begin
        body     = {1'b0, header_reg[60:56]} + 6'd1;
        alen     = (cmd_reg == CMD_SHORT_AUTH) ? 4'(SHORT_AUTH_LEN) : 4'(FULL_AUTH_LEN);
        over     = 6'(BASE_OVERHEAD) + {2'b00, alen};
        fits     = body >= over;
        pl       = fits ? body - over : 6'd0;
        pos7     = {1'b0, pos_reg};
        pay_end  = 7'd9 + {1'b0, pl};
        cnt_end  = pay_end + 7'd2;
        auth_end = cnt_end + {3'b000, alen};
    end

    always_comb
    begin
        crc_next     = (pos_reg >= 6'd2) ? crc_byte(crc_reg, held0_reg, poly_reg) : crc_reg;
        held0_next   = held1_reg;
        held1_next   = data_byte;
        header_next  = header_reg;
        cmd_next     = cmd_reg;
        counter_next = counter_reg;
        auth_next    = auth_reg;
        is_payload   = 1'b0;

        if (pos7 < 7'(HDR_BYTES))
            header_next = {header_reg[55:0], data_byte};
        else if (pos7 == 7'(CMD_POS))
            cmd_next = data_byte;
        else if (fits)
        begin
            if (pos7 < pay_end)
                is_payload = 1'b1;
            else if (pos7 < cnt_end)
                counter_next = {counter_reg[7:0], data_byte};
            else if (pos7 < auth_end)
                auth_next = {auth_reg[39:0], data_byte};
        end

        pos_next = (pos_reg < 6'(POS_MAX)) ? pos_reg + 6'd1 : pos_reg;
    end

    // end-of-frame checks use the fully updated capture
    always_comb
    begin
        body_f = {1'b0, header_next[60:56]} + 6'd1;
        alen_f = (cmd_next == CMD_SHORT_AUTH) ? 4'(SHORT_AUTH_LEN) : 4'(FULL_AUTH_LEN);
        over_f = 6'(BASE_OVERHEAD) + {2'b00, alen_f};
        len7   = pos7 + 7'd1;
        rx_crc = {held1_next, held0_next};

        if (len7 < 7'(MIN_FRAME))
            st = ST_TOO_SHORT;
        else if (crc_next != rx_crc)
            st = ST_CRC_MISMATCH;
        else if ({1'b0, body_f} != len7 - 7'd2)
            st = ST_LEN_MISMATCH;
        else if (body_f < over_f)
            st = ST_OVERHEAD;
        else
            st = ST_OK;
    end

    always_comb
    begin
        res = '0;
        if (last_byte)
        begin
            res.kind   = 1'b1;
            res.status = st;
            if (st == ST_OK)
            begin
                res.control_first   = header_next[63:56];
                res.control_second  = header_next[55:48];
                res.dest_address    = header_next[47:24];
                res.source_address  = header_next[23:0];
                res.command         = cmd_next;
                res.rolling_counter = counter_next;
                res.auth_code       = auth_next;
                res.auth_len        = alen_f;
                res.payload_len     = 5'(body_f - over_f);
            end
        end
        else
        begin
            res.kind         = 1'b0;
            res.payload_byte = data_byte;
        end
    end

    assign res_valid = accept && (last_byte || is_payload);

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || out_ready)
        begin
            // no new transaction can arrive while the skid holds one
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_reg <= CRC_POLY_RESET;
        else if (cfg_wr_en)
            poly_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= '0;
            held0_reg   <= '0;
            held1_reg   <= '0;
            header_reg  <= '0;
            cmd_reg     <= '0;
            counter_reg <= '0;
            auth_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg     <= '0;
                crc_reg     <= '0;
                held0_reg   <= '0;
                held1_reg   <= '0;
                header_reg  <= '0;
                cmd_reg     <= '0;
                counter_reg <= '0;
                auth_reg    <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                held0_reg   <= held0_next;
                held1_reg   <= held1_next;
                header_reg  <= header_next;
                cmd_reg     <= cmd_next;
                counter_reg <= counter_next;
                auth_reg    <= auth_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign payload_byte    = out_reg.payload_byte;
    assign status          = out_reg.status;
    assign control_first   = out_reg.control_first;
    assign control_second  = out_reg.control_second;
    assign dest_address    = out_reg.dest_address;
    assign source_address  = out_reg.source_address;
    assign command         = out_reg.command;
    assign rolling_counter = out_reg.rolling_counter;
    assign auth_code       = out_reg.auth_code;
    assign auth_len        = out_reg.auth_len;
    assign payload_len     = out_reg.payload_len;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction with the output empty");

    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (pos_reg == '0 && crc_reg == '0 && cmd_reg == '0))
        else $error("frame state not cleared after last byte");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_byte && pos_reg == 6'(POS_MAX)) |=> (pos_reg == 6'(POS_MAX)))
        else $error("byte position wrapped");

    a_bad_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind && out_reg.status != ST_OK)
            |-> (out_reg.dest_address == '0 && out_reg.auth_code == '0
                 && out_reg.payload_len == '0))
        else $error("failed summary carries field data");

    a_payload_only_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_payload) |-> (pos_reg > 6'(CMD_POS)))
        else $error("payload byte flagged inside the header");
`endif

endmodule
